@@ hw/rtl/dlmr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlmr_pkg
// Shared sizes, operation codes and controller/datapath interface types for
// the dense layer block.
// ----------------------------------------------------------------------------
package dlmr_pkg;

  localparam int INPUT_COUNT   = 256;
  localparam int OUTPUT_COUNT  = 16;
  localparam int FRACTION_BITS = 8;
  localparam int WEIGHT_TOTAL  = INPUT_COUNT * OUTPUT_COUNT;

  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 32;
  localparam int INDEX_W  = 6;
  localparam int PROD_W   = 2 * VALUE_W;
  localparam int ACC_W    = 48;

  localparam int ACT_AW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int ACT_CW = $clog2(INPUT_COUNT + 1);
  localparam int W_AW   = (WEIGHT_TOTAL > 1) ? $clog2(WEIGHT_TOTAL) : 1;
  localparam int W_CW   = $clog2(WEIGHT_TOTAL + 1);
  localparam int OUT_AW = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
  localparam int B_CW   = $clog2(OUTPUT_COUNT + 1);

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_ACT    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic                      wr_weight;
    logic                      wr_bias;
    logic                      wr_act;
    logic [W_AW-1:0]           wr_w_addr;
    logic [OUT_AW-1:0]         wr_b_addr;
    logic [ACT_AW-1:0]         wr_a_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic [W_AW-1:0]           rd_w_addr;
    logic [ACT_AW-1:0]         rd_a_addr;
    logic [OUT_AW-1:0]         rd_idx;
    logic                      rd_first;
    logic                      rd_end;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

@@ hw/rtl/dlmr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlmr_ctrl
// Load sequencing and multiply-accumulate scheduling for the dense layer.
// ----------------------------------------------------------------------------
module dlmr_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [1:0]                          in_operation,
  input  logic signed [dlmr_pkg::VALUE_W-1:0] in_value,
  input  dlmr_pkg::dp_status_t                status,
  output logic                                busy,
  output dlmr_pkg::dp_cmd_t                   cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MAC   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                         state_r, state_nxt;
  logic [dlmr_pkg::W_CW-1:0]      w_cnt_r, w_cnt_nxt;
  logic [dlmr_pkg::B_CW-1:0]      b_cnt_r, b_cnt_nxt;
  logic [dlmr_pkg::ACT_CW-1:0]    a_cnt_r, a_cnt_nxt;
  logic [dlmr_pkg::ACT_AW-1:0]    i_r, i_nxt;
  logic [dlmr_pkg::OUT_AW-1:0]    j_r, j_nxt;
  logic [dlmr_pkg::W_AW-1:0]      waddr_r, waddr_nxt;
  logic                           i_end;

  assign busy  = (state_r != S_IDLE);
  assign i_end = (i_r == dlmr_pkg::ACT_AW'(dlmr_pkg::INPUT_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    w_cnt_nxt = w_cnt_r;
    b_cnt_nxt = b_cnt_r;
    a_cnt_nxt = a_cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    waddr_nxt = waddr_r;

    cmd           = '0;
    cmd.wr_data   = in_value;
    cmd.wr_w_addr = w_cnt_r[dlmr_pkg::W_AW-1:0];
    cmd.wr_b_addr = b_cnt_r[dlmr_pkg::OUT_AW-1:0];
    cmd.wr_a_addr = a_cnt_r[dlmr_pkg::ACT_AW-1:0];
    cmd.rd_w_addr = waddr_r;
    cmd.rd_a_addr = i_r;
    cmd.rd_idx    = j_r;
    cmd.rd_first  = (i_r == '0);
    cmd.rd_end    = i_end;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (dlmr_pkg::op_t'(in_operation))
            dlmr_pkg::OP_WEIGHT: begin
              if (w_cnt_r != dlmr_pkg::W_CW'(dlmr_pkg::WEIGHT_TOTAL)) begin
                cmd.wr_weight = 1'b1;
                w_cnt_nxt     = w_cnt_r + 1'b1;
              end
            end
            dlmr_pkg::OP_BIAS: begin
              if (b_cnt_r != dlmr_pkg::B_CW'(dlmr_pkg::OUTPUT_COUNT)) begin
                cmd.wr_bias = 1'b1;
                b_cnt_nxt   = b_cnt_r + 1'b1;
              end
            end
            dlmr_pkg::OP_ACT: begin
              if (a_cnt_r != dlmr_pkg::ACT_CW'(dlmr_pkg::INPUT_COUNT)) begin
                cmd.wr_act = 1'b1;
                a_cnt_nxt  = a_cnt_r + 1'b1;
              end
            end
            dlmr_pkg::OP_NONE: ;
            default: ;
          endcase
          // full vector with all coefficients held: run the layer
          if ((a_cnt_nxt == dlmr_pkg::ACT_CW'(dlmr_pkg::INPUT_COUNT)) &&
              (w_cnt_nxt == dlmr_pkg::W_CW'(dlmr_pkg::WEIGHT_TOTAL)) &&
              (b_cnt_nxt == dlmr_pkg::B_CW'(dlmr_pkg::OUTPUT_COUNT))) begin
            state_nxt = S_MAC;
            a_cnt_nxt = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            waddr_nxt = '0;
          end
        end
      end
      S_MAC: begin
        cmd.rd_en = 1'b1;
        if (i_end) begin
          // next output neuron starts at weight (0, j+1)
          i_nxt     = '0;
          j_nxt     = j_r + 1'b1;
          waddr_nxt = dlmr_pkg::W_AW'(j_r) + dlmr_pkg::W_AW'(1);
          if (j_r == dlmr_pkg::OUT_AW'(dlmr_pkg::OUTPUT_COUNT - 1)) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          waddr_nxt = waddr_r + dlmr_pkg::W_AW'(dlmr_pkg::OUTPUT_COUNT);
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      w_cnt_r <= '0;
      b_cnt_r <= '0;
      a_cnt_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      waddr_r <= '0;
    end else begin
      state_r <= state_nxt;
      w_cnt_r <= w_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
      a_cnt_r <= a_cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      waddr_r <= waddr_nxt;
    end
  end

  a_coeff_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |->
      ((w_cnt_r == dlmr_pkg::W_CW'(dlmr_pkg::WEIGHT_TOTAL)) &&
       (b_cnt_r == dlmr_pkg::B_CW'(dlmr_pkg::OUTPUT_COUNT))))
    else $error("layer running without full coefficient set");

  a_vector_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (a_cnt_r == '0))
    else $error("activation count not cleared for compute");

  a_run_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_MAC) |-> ((i_r == '0) && (j_r == '0) && (waddr_r == '0)))
    else $error("compute did not start at first weight");

  a_row_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MAC) && (i_r == '0)) |-> (waddr_r == dlmr_pkg::W_AW'(j_r)))
    else $error("weight address out of step with output index");

endmodule

@@ hw/rtl/dlmr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlmr_datapath
// Coefficient and activation stores, multiply-accumulate pipeline,
// saturation, ReLU and result register.
// ----------------------------------------------------------------------------
module dlmr_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dlmr_pkg::dp_cmd_t                     cmd,
  input  logic                                  cfg_write_en,
  input  logic                                  cfg_write_data,
  output dlmr_pkg::dp_status_t                  status,
  output logic                                  out_valid,
  output logic signed [dlmr_pkg::RESULT_W-1:0]  out_result_value,
  output logic [dlmr_pkg::INDEX_W-1:0]          out_result_index,
  output logic                                  out_result_last
);

  logic signed [dlmr_pkg::VALUE_W-1:0] w_mem [dlmr_pkg::WEIGHT_TOTAL];
  logic signed [dlmr_pkg::VALUE_W-1:0] a_mem [dlmr_pkg::INPUT_COUNT];
  logic signed [dlmr_pkg::VALUE_W-1:0] b_regs [dlmr_pkg::OUTPUT_COUNT];

  logic                                 mode_r;

  logic signed [dlmr_pkg::VALUE_W-1:0]  w_q_r, a_q_r;
  logic                                 s1_v_r, s1_first_r, s1_end_r;
  logic [dlmr_pkg::OUT_AW-1:0]          s1_idx_r;

  logic signed [dlmr_pkg::PROD_W-1:0]   prod_r;
  logic                                 s2_v_r, s2_first_r, s2_end_r;
  logic [dlmr_pkg::OUT_AW-1:0]          s2_idx_r;

  logic signed [dlmr_pkg::ACC_W-1:0]    acc_r, acc_nxt, bias_ext;
  logic                                 s3_end_r;
  logic [dlmr_pkg::OUT_AW-1:0]          s3_idx_r;

  logic                                 pos_ovf, neg_ovf;
  logic signed [dlmr_pkg::RESULT_W-1:0] sat_val, res_nxt;

  logic                                 out_valid_r;
  logic signed [dlmr_pkg::RESULT_W-1:0] out_value_r;
  logic [dlmr_pkg::INDEX_W-1:0]         out_index_r;
  logic                                 out_last_r;

  // weight and activation stores: one write port from loads, one registered read port for compute
  always_ff @(posedge clk) begin
    if (cmd.wr_weight) begin
      w_mem[cmd.wr_w_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      w_q_r <= w_mem[cmd.rd_w_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_act) begin
      a_mem[cmd.wr_a_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      a_q_r <= a_mem[cmd.rd_a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_bias) begin
      b_regs[cmd.wr_b_addr] <= cmd.wr_data;
    end
  end

  // bias seeds the accumulator, aligned to the product scale
  assign bias_ext = dlmr_pkg::ACC_W'(b_regs[s2_idx_r]) <<< dlmr_pkg::FRACTION_BITS;

  always_comb begin
    acc_nxt = acc_r;
    if (s2_v_r) begin
      acc_nxt = (s2_first_r ? bias_ext : acc_r) + dlmr_pkg::ACC_W'(prod_r);
    end
  end

  assign pos_ovf = !acc_r[dlmr_pkg::ACC_W-1] &&
                   (|acc_r[dlmr_pkg::ACC_W-2:dlmr_pkg::RESULT_W-1]);
  assign neg_ovf = acc_r[dlmr_pkg::ACC_W-1] &&
                   !(&acc_r[dlmr_pkg::ACC_W-2:dlmr_pkg::RESULT_W-1]);

  always_comb begin
    if (pos_ovf) begin
      sat_val = {1'b0, {(dlmr_pkg::RESULT_W-1){1'b1}}};
    end else if (neg_ovf) begin
      sat_val = {1'b1, {(dlmr_pkg::RESULT_W-1){1'b0}}};
    end else begin
      sat_val = acc_r[dlmr_pkg::RESULT_W-1:0];
    end
    res_nxt = sat_val;
    if (mode_r && (sat_val[dlmr_pkg::RESULT_W-1] || (sat_val == '0))) begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_end_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        mode_r <= cfg_write_data;
      end
      s1_v_r      <= cmd.rd_en;
      s2_v_r      <= s1_v_r;
      s3_end_r    <= s2_v_r && s2_end_r;
      out_valid_r <= s3_end_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.rd_first;
    s1_end_r   <= cmd.rd_end;
    s1_idx_r   <= cmd.rd_idx;
    prod_r     <= w_q_r * a_q_r;
    s2_first_r <= s1_first_r;
    s2_end_r   <= s1_end_r;
    s2_idx_r   <= s1_idx_r;
    acc_r      <= acc_nxt;
    s3_idx_r   <= s2_idx_r;
    if (s3_end_r) begin
      out_value_r <= res_nxt;
      out_index_r <= dlmr_pkg::INDEX_W'(s3_idx_r);
      out_last_r  <= (s3_idx_r == dlmr_pkg::OUT_AW'(dlmr_pkg::OUTPUT_COUNT - 1));
    end
  end

  assign status.pipe_busy = s1_v_r | s2_v_r | s3_end_r;

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_index = out_index_r;
  assign out_result_last  = out_last_r;

endmodule

@@ hw/rtl/dense_layer_mac_relu_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_mac_relu_top
// Fully connected layer with optional ReLU: one multiply-accumulate per cycle.
// ----------------------------------------------------------------------------
// weight, bias and activation loads leave busy low;
// the request that leaves a full vector and all coefficients held starts a
// run of INPUT_COUNT * OUTPUT_COUNT multiply-accumulates through the single MAC unit;
// results strobe out_valid in index order, one per output neuron;
// busy falls the cycle after the last result
// synchronous active-low reset clears state, counts, indices, mode and pipeline valids only
module dense_layer_mac_relu_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_operation,
  input  logic signed [dlmr_pkg::VALUE_W-1:0]   in_value,
  input  logic                                  cfg_write_en,
  input  logic                                  cfg_write_data,
  output logic                                  out_valid,
  output logic signed [dlmr_pkg::RESULT_W-1:0]  out_result_value,
  output logic [dlmr_pkg::INDEX_W-1:0]          out_result_index,
  output logic                                  out_result_last
);

  dlmr_pkg::dp_cmd_t    cmd;
  dlmr_pkg::dp_status_t status;

  dlmr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .in_value     (in_value),
    .status       (status),
    .busy         (busy),
    .cmd          (cmd)
  );

  dlmr_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .status           (status),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_result_index (out_result_index),
    .out_result_last  (out_result_last)
  );

endmodule
